[hw/rtl/timer_status_interrupt_unit_defines.svh]
// Assertion macros shared by the timer, status and interrupt unit.
// No dependencies; included by the RTL files that carry assertions.
`ifndef TIMER_STATUS_INTERRUPT_UNIT_DEFINES_SVH
`define TIMER_STATUS_INTERRUPT_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked assertion that also holds during reset.
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK_RST(lbl, clk, rst, prop, msg)
`define ASSERT_CLK(lbl, clk, prop, msg)
`endif
`endif

[hw/rtl/tsiu_pkg.sv]
// Types and constants of the timer, status and interrupt unit.
// No dependencies; used by the core and the top level.
`timescale 1ns / 1ps
`default_nettype none
package tsiu_pkg;

  // Operation codes of one input item.
  localparam logic [2:0] OP_READ       = 3'd0;
  localparam logic [2:0] OP_READ_CLEAR = 3'd1;
  localparam logic [2:0] OP_COMMAND    = 3'd2;
  localparam logic [2:0] OP_TICK       = 3'd3;
  localparam logic [2:0] OP_FLOPPY     = 3'd4;
  localparam logic [2:0] OP_PRINTER    = 3'd5;

  // Command codes and the range that maps onto peripheral commands.
  localparam logic [7:0] CMD_RESET      = 8'd1;
  localparam logic [7:0] CMD_MODE_FIRST = 8'd2;
  localparam logic [7:0] CMD_MODE_LAST  = 8'd4;
  localparam logic [7:0] CMD_PERI_FIRST = 8'd5;
  localparam logic [7:0] CMD_PERI_LAST  = 8'd12;
  localparam logic [7:0] CMD_PERI_BIAS  = 8'd3;

  // Peripheral command codes on the result.
  localparam logic [3:0] PCMD_NONE  = 4'd0;
  localparam logic [3:0] PCMD_RESET = 4'd1;

  // Floppy interrupt modes.
  localparam logic [2:0] FMODE_NMI  = 3'd2;
  localparam logic [2:0] FMODE_INT  = 3'd3;
  localparam logic [2:0] FMODE_NONE = 3'd4;

  // Tick counters: retrace is active for the first few phases of a period.
  localparam logic [4:0] RETRACE_PERIOD       = 5'd18;
  localparam logic [4:0] RETRACE_ACTIVE_TICKS = 5'd3;
  localparam logic [1:0] TICKS_PER_COUNT      = 2'd3;
  localparam logic [3:0] COUNT_MAX            = 4'hF;

  // Unit state. Status bit 4 is always one and bit 7 always zero, so only
  // the varying status bits are stored.
  typedef struct packed {
    logic [3:0] count;
    logic       floppy_flag;
    logic       retrace_flag;
    logic [2:0] floppy_int_mode;
    logic [1:0] tick_divider;
    logic [4:0] retrace_phase;
    logic       printer_pending;
  } state_t;

  // One input item.
  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] command_byte;
    logic       irq_level;
    logic       cpu_iff1;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [7:0] read_data;
    logic       int_request;
    logic       nmi_request;
    logic [3:0] peripheral_command;
  } result_t;

endpackage
`default_nettype wire

[hw/rtl/tsiu_if.sv]
// Valid/ready channel interfaces for the item and result streams.
// No dependencies; instantiated around timer_status_interrupt_unit.
`timescale 1ns / 1ps
`default_nettype none

// Input item channel.
interface tsiu_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] command_byte;
  logic       irq_level;
  logic       cpu_iff1;

  modport source (output valid, operation, command_byte, irq_level, cpu_iff1,
                  input ready);
  modport sink (input valid, operation, command_byte, irq_level, cpu_iff1,
                output ready);
endinterface

// Result item channel.
interface tsiu_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       int_request;
  logic       nmi_request;
  logic [3:0] peripheral_command;

  modport source (output valid, read_data, int_request, nmi_request,
                  peripheral_command, input ready);
  modport sink (input valid, read_data, int_request, nmi_request,
                peripheral_command, output ready);
endinterface
`default_nettype wire

[hw/rtl/tsiu_core.sv]
// Next-state and result logic for one item of the status/interrupt unit.
// Depends on tsiu_pkg; purely combinational, instantiated by the top level.
`timescale 1ns / 1ps
`default_nettype none
module tsiu_core (
  input  tsiu_pkg::state_t  state,
  input  tsiu_pkg::item_t   item,
  output tsiu_pkg::state_t  state_next,
  output tsiu_pkg::result_t result
);
  import tsiu_pkg::*;

  logic [4:0] phase_inc;
  logic [4:0] phase_new;
  logic [1:0] div_inc;
  logic [3:0] peri_diff;
  logic [7:0] status_now;

  // Status byte as the CPU sees it before this item.
  assign status_now = {1'b0, state.retrace_flag, state.floppy_flag, 1'b1, state.count};

  // Counter increments used by a tick.
  assign phase_inc = state.retrace_phase + 5'd1;
  assign phase_new = (phase_inc >= RETRACE_PERIOD) ? 5'd0 : phase_inc;
  assign div_inc   = state.tick_divider + 2'd1;
  // Only the low nibble matters: peripheral codes run from 2 to 9.
  assign peri_diff = item.command_byte[3:0] - CMD_PERI_BIAS[3:0];

  // Operation decode.
  always_comb begin
    state_next = state;
    result     = '0;
    unique case (item.operation)
      OP_READ: begin
        result.read_data = status_now;
      end
      OP_READ_CLEAR: begin
        result.read_data = status_now;
        state_next.count = 4'd0;
      end
      OP_COMMAND: begin
        if (item.command_byte == CMD_RESET) begin
          result.peripheral_command = PCMD_RESET;
        end else if (item.command_byte >= CMD_PERI_FIRST &&
                     item.command_byte <= CMD_PERI_LAST) begin
          result.peripheral_command = peri_diff;
        end else if (item.command_byte >= CMD_MODE_FIRST &&
                     item.command_byte <= CMD_MODE_LAST) begin
          state_next.floppy_int_mode = item.command_byte[2:0];
        end
      end
      OP_TICK: begin
        state_next.retrace_phase = phase_new;
        state_next.retrace_flag  = (phase_new < RETRACE_ACTIVE_TICKS);
        if (div_inc >= TICKS_PER_COUNT) begin
          // Counting tick: bump the saturating count, raise INT if enabled.
          state_next.tick_divider = 2'd0;
          if (state.count != COUNT_MAX) begin
            state_next.count = state.count + 4'd1;
          end
          result.int_request = item.cpu_iff1;
        end else begin
          // Other ticks forward a pending floppy or printer interrupt.
          state_next.tick_divider = div_inc;
          if (state.floppy_flag) begin
            result.nmi_request = (state.floppy_int_mode == FMODE_NMI);
            result.int_request = (state.floppy_int_mode == FMODE_INT);
          end else begin
            result.int_request = state.printer_pending;
          end
        end
      end
      OP_FLOPPY: begin
        state_next.floppy_flag = item.irq_level;
      end
      OP_PRINTER: begin
        state_next.printer_pending = item.irq_level;
      end
      default: begin
      end
    endcase
  end
endmodule
`default_nettype wire

[hw/rtl/timer_status_interrupt_unit.sv]
// Status and interrupt unit of a home computer gate array: the top level.
// One input item (status read, read-and-clear, command write, timer tick,
// floppy or printer interrupt level) is taken per cycle and yields exactly
// one result item in the cycle after its transfer. The whole update is done by
// the core logic between the input handshake and a single output register,
// so the sustained rate is one item per clock; the input is held off only
// while that output register is full and its result is not being taken.
// Depends on tsiu_pkg, tsiu_if and tsiu_core.
`timescale 1ns / 1ps
`default_nettype none
`include "timer_status_interrupt_unit_defines.svh"
module timer_status_interrupt_unit (
  input  wire        clk,
  input  wire        rst,
  tsiu_req_if.sink   req,
  tsiu_rsp_if.source rsp
);
  import tsiu_pkg::*;

  state_t  state;
  state_t  state_next;
  item_t   item;
  result_t result;
  result_t result_reg;
  logic    out_valid;
  logic    req_fire;

  // Input transfer whenever the output register is free or being emptied.
  assign req.ready = !out_valid || rsp.ready;
  assign req_fire  = req.valid && req.ready;

  assign item = '{operation:    req.operation,
                  command_byte: req.command_byte,
                  irq_level:    req.irq_level,
                  cpu_iff1:     req.cpu_iff1};

  tsiu_core u_core (
    .state      (state),
    .item       (item),
    .state_next (state_next),
    .result     (result)
  );

  // Unit state, updated on every input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.count           <= 4'd0;
      state.floppy_flag     <= 1'b1;
      state.retrace_flag    <= 1'b0;
      state.floppy_int_mode <= FMODE_NONE;
      state.tick_divider    <= 2'd0;
      state.retrace_phase   <= 5'd0;
      state.printer_pending <= 1'b0;
    end else if (req_fire) begin
      state <= state_next;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (req_fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      result_reg <= result;
    end
  end

  assign rsp.valid              = out_valid;
  assign rsp.read_data          = result_reg.read_data;
  assign rsp.int_request        = result_reg.int_request;
  assign rsp.nmi_request        = result_reg.nmi_request;
  assign rsp.peripheral_command = result_reg.peripheral_command;

  // The two interrupt pulses never come from the same item.
  `ASSERT_CLK_RST(a_int_nmi_excl, clk, rst, rsp.valid |-> !(rsp.int_request && rsp.nmi_request), "INT and NMI raised together")
  // A command result carries nothing else.
  `ASSERT_CLK_RST(a_cmd_alone, clk, rst, (rsp.valid && rsp.peripheral_command != PCMD_NONE) |-> (rsp.read_data == 8'd0 && !rsp.int_request && !rsp.nmi_request), "command result mixed with other fields")
  // Any status read shows the fixed bit.
  `ASSERT_CLK_RST(a_status_fixed, clk, rst, (rsp.valid && rsp.read_data != 8'd0) |-> rsp.read_data[4], "status read without fixed bit")
  // The retrace phase stays inside its period.
  `ASSERT_CLK_RST(a_phase_range, clk, rst, state.retrace_phase < RETRACE_PERIOD, "retrace phase out of range")
  // A saturated count stays saturated across a tick.
  `ASSERT_CLK_RST(a_count_sat, clk, rst, (req_fire && req.operation == OP_TICK && state.count == COUNT_MAX) |=> (state.count == COUNT_MAX), "count wrapped past saturation")
endmodule
`default_nettype wire
